[rtl/rspm_pkg.sv]
// shared types, codes and fixed widths of the record slot page manager
package rspm_pkg;

    // page geometry
    localparam int PAGE_BYTES   = 8192;
    localparam int HEADER_BYTES = 20;

    // field widths
    localparam int CFG_W       = 13;
    localparam int REQ_W       = 3;
    localparam int SLOT_IN_W   = 11;
    localparam int STATUS_W    = 3;
    localparam int SLOT_OUT_W  = 10;
    localparam int OFFSET_W    = 13;
    localparam int COUNT_W     = 11;
    localparam int STRIDE_W    = 13;
    localparam int MAX_RECORD  = 4096;

    // stream word layout
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 4;
    localparam int M_PAD_W   = M_TDATA_W - SLOT_OUT_W - OFFSET_W - COUNT_W;

    // occupancy map word
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // capacity divider: floor(8*avail / (8*stride + 1))
    localparam int AVAIL   = (PAGE_BYTES > HEADER_BYTES + 1) ?
                             (PAGE_BYTES - HEADER_BYTES - 1) : 0;
    localparam int DIV_NUM = 8 * AVAIL;
    localparam int NUM_W   = $clog2(DIV_NUM + 1);
    localparam int DEN_W   = STRIDE_W + 3;
    localparam int DCNT_W  = $clog2(NUM_W + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT  = 3'd0,
        REQ_RECOVER = 3'd1,
        REQ_UPDATE  = 3'd2,
        REQ_DELETE  = 3'd3,
        REQ_GET     = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_BAD_ARG   = 3'd2,
        ST_NOT_EXIST = 3'd3,
        ST_BAD_RID   = 3'd4
    } status_t;

endpackage

[rtl/record_slot_page_manager.sv]
// record slot page manager: occupancy map, record count and slot geometry of one page
//
// Each request word (s_axis_tuser = request kind, s_axis_tdata = slot) gives exactly one
// result word. A request passes the sequencer states S_EXEC and S_OFFS on its way to the
// result register, and no further request is taken until it has left them: the occupancy
// map lives in a synchronous memory of 32-bit words, read on acceptance, modified and
// written back in the next cycle, and the byte offset is formed by a multiplier in the
// cycle after that. Insert finds the lowest free slot through a one-bit-per-word "full"
// summary, then a find-first-zero on the word read. A record size write empties the page
// at once (per-word valid bits) and recomputes the capacity with a bit-serial divider,
// and until the new capacity is stored no request or further size write is taken. A
// finished result may wait in the output register while the next request is accepted;
// that next result then waits in the sequencer, and no further request is taken, until the first is taken.
module record_slot_page_manager #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // record size write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rspm_pkg::CFG_W-1:0]     cfg_data,
    // request words
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [rspm_pkg::S_TDATA_W-1:0] s_axis_tdata,  // slot_index[10:0], zeros
    input  logic [rspm_pkg::S_TUSER_W-1:0] s_axis_tuser,  // req_type[2:0]
    // result words
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rspm_pkg::M_TDATA_W-1:0] m_axis_tdata,  // slot_out[9:0],
                                                          // data_offset[22:10],
                                                          // record_count[33:23], zeros
    output logic [rspm_pkg::M_TUSER_W-1:0] m_axis_tuser   // status[2:0], page_empty[3]
);
    import rspm_pkg::*;

    localparam int WORDS   = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_W  = WIDX_W + BIT_W;
    localparam int SX      = (SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W;
    localparam int CAP_W   = $clog2(MAX_SLOTS + 1);
    localparam int CMP_A   = (SX > CAP_W) ? SX : CAP_W;
    localparam int CMP_W   = (CMP_A > NUM_W) ? CMP_A : NUM_W;
    localparam int RST_RAW = DIV_NUM / 65;
    localparam int RST_CAP = (RST_RAW > MAX_SLOTS) ? MAX_SLOTS : RST_RAW;
    localparam int RST_DS  = ((HEADER_BYTES + (RST_CAP + 7) / 8 + 7) / 8) * 8;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_OFFS = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    // control state
    state_t                 state_reg;
    logic [WORDS-1:0]       full_reg;
    logic [WORDS-1:0]       row_valid_reg;
    logic [CAP_W-1:0]       count_reg;
    logic [CAP_W-1:0]       cap_reg;
    logic [STRIDE_W-1:0]    stride_reg;
    logic [OFFSET_W-1:0]    ds_reg;
    logic [DCNT_W-1:0]      div_cnt_reg;
    logic                   out_valid_reg;

    // payload registers
    logic [NUM_W-1:0]       quo_reg;
    logic [DEN_W-1:0]       rem_reg;
    req_t                   req_reg;
    logic [SX-1:0]          slot_reg;
    logic [WIDX_W-1:0]      word_reg;
    logic                   any_free_reg;
    logic                   in_range_reg;
    logic                   rd_valid_reg;
    logic [WORD_BITS-1:0]   rd_data_reg;
    status_t                res_status_reg;
    logic                   res_ok_reg;
    logic [SX-1:0]          res_slot_reg;
    logic                   res_empty_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [SLOT_OUT_W-1:0]  out_slot_reg;
    logic [OFFSET_W-1:0]    out_offset_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic                   out_empty_reg;

    // occupancy map memory
    logic [WORD_BITS-1:0]   map_mem [WORDS];

    logic                   in_accept;
    logic                   cfg_accept;
    logic                   out_load;

    // handshakes
    assign cfg_ready     = (state_reg == S_IDLE);
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_accept    = cfg_valid && cfg_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_OFFS) && (!out_valid_reg || m_axis_tready);

    // record size saturation and stride
    logic [CFG_W-1:0]       size_sat;
    logic [STRIDE_W-1:0]    stride_next;

    always_comb
    begin
        priority if (cfg_data == '0)
            size_sat = CFG_W'(1);
        else if (cfg_data > CFG_W'(MAX_RECORD))
            size_sat = CFG_W'(MAX_RECORD);
        else
            size_sat = cfg_data;
        stride_next = STRIDE_W'((size_sat + CFG_W'(7)) & ~CFG_W'(7));
    end

    // one restoring division step
    logic [DEN_W-1:0]       den;
    logic [DEN_W:0]         trial;
    logic                   trial_ge;
    logic [DEN_W-1:0]       rem_next;
    logic [NUM_W-1:0]       quo_next;

    always_comb
    begin
        den      = {stride_reg, 3'b000} + DEN_W'(1);
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        trial_ge = (trial >= {1'b0, den});
        rem_next = trial_ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        quo_next = {quo_reg[NUM_W-2:0], trial_ge};
    end

    // capacity clamp and first record offset
    logic [CAP_W-1:0]       cap_next;
    logic [15:0]            ds_sum;
    logic [OFFSET_W-1:0]    ds_next;

    always_comb
    begin
        if (CMP_W'(quo_reg) > CMP_W'(MAX_SLOTS))
            cap_next = CAP_W'(MAX_SLOTS);
        else
            cap_next = CAP_W'(quo_reg);
        ds_sum  = 16'(HEADER_BYTES) + ((16'(cap_next) + 16'd7) >> 3) + 16'd7;
        ds_next = OFFSET_W'(ds_sum & ~16'd7);
    end

    // request decode at acceptance: pick the map word to read
    logic [SX-1:0]          slot_in;
    logic                   slot_in_range;
    logic [WIDX_W-1:0]      free_word;
    logic                   any_free;
    logic [WIDX_W-1:0]      rd_addr;

    always_comb
    begin
        slot_in       = SX'(s_axis_tdata[SLOT_IN_W-1:0]);
        slot_in_range = CMP_W'(slot_in) < CMP_W'(cap_reg);
        free_word     = '0;
        any_free      = 1'b0;
        for (int i = WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                any_free  = 1'b1;
                free_word = WIDX_W'(i);
            end
        end
        if (req_t'(s_axis_tuser[REQ_W-1:0]) == REQ_INSERT)
            rd_addr = free_word;
        else if (slot_in_range)
            rd_addr = slot_in[BIT_W +: WIDX_W];
        else
            rd_addr = '0;
    end

    // memory read and write ports
    logic                   mem_we;
    logic [WORD_BITS-1:0]   mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[word_reg] <= mem_wdata;
        if (in_accept)
            rd_data_reg <= map_mem[rd_addr];
    end

    // modify step: find-first-zero, status and new word
    logic [WORD_BITS-1:0]   word;
    logic                   zero_found;
    logic [BIT_W-1:0]       zero_bit;
    logic [BIT_W-1:0]       bit_sel;
    logic [WORD_BITS-1:0]   bit_mask;
    logic [SLOT_W-1:0]      found_slot;
    logic                   found_ok;
    logic                   room;
    status_t                ex_status;
    logic                   ex_ok;
    logic [SX-1:0]          ex_slot;
    logic [CAP_W-1:0]       ex_count;
    logic                   ex_empty;

    always_comb
    begin
        word       = rd_valid_reg ? rd_data_reg : '0;
        zero_found = 1'b0;
        zero_bit   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                zero_found = 1'b1;
                zero_bit   = BIT_W'(i);
            end
        end
        bit_sel    = (req_reg == REQ_INSERT) ? zero_bit : slot_reg[BIT_W-1:0];
        bit_mask   = WORD_BITS'(1) << bit_sel;
        found_slot = {word_reg, zero_bit};
        found_ok   = any_free_reg && zero_found && (CMP_W'(found_slot) < CMP_W'(cap_reg));
        room       = (count_reg < cap_reg);
        ex_status  = ST_OK;
        ex_ok      = 1'b0;
        ex_slot    = slot_reg;
        ex_count   = count_reg;
        ex_empty   = 1'b0;
        mem_we     = 1'b0;
        mem_wdata  = word;
        unique case (req_reg)
            REQ_INSERT:
            begin
                if (room && found_ok)
                begin
                    ex_ok     = 1'b1;
                    ex_slot   = SX'(found_slot);
                    ex_count  = count_reg + CAP_W'(1);
                    mem_we    = (state_reg == S_EXEC);
                    mem_wdata = word | bit_mask;
                end
                else
                begin
                    ex_status = ST_NO_SPACE;
                    ex_slot   = '0;
                end
            end
            REQ_RECOVER:
            begin
                if (room && in_range_reg)
                begin
                    ex_ok     = 1'b1;
                    ex_count  = count_reg + CAP_W'(1);
                    mem_we    = (state_reg == S_EXEC);
                    mem_wdata = word | bit_mask;
                end
                else
                    ex_status = ST_NO_SPACE;
            end
            REQ_UPDATE, REQ_GET:
            begin
                if (!in_range_reg)
                    ex_status = (req_reg == REQ_UPDATE) ? ST_BAD_ARG : ST_BAD_RID;
                else if (!word[bit_sel])
                    ex_status = ST_NOT_EXIST;
                else
                    ex_ok = 1'b1;
            end
            REQ_DELETE:
            begin
                if (!in_range_reg)
                    ex_status = ST_BAD_ARG;
                else if (!word[bit_sel])
                    ex_status = ST_NOT_EXIST;
                else
                begin
                    ex_ok     = 1'b1;
                    ex_count  = (count_reg != '0) ? count_reg - CAP_W'(1) : '0;
                    ex_empty  = (ex_count == '0);
                    mem_we    = (state_reg == S_EXEC);
                    mem_wdata = word & ~bit_mask;
                end
            end
            default:
                ex_status = ST_BAD_ARG;
        endcase
    end

    // byte offset of the slot's record
    logic [OFFSET_W-1:0]    offset_next;

    assign offset_next = res_ok_reg ?
        OFFSET_W'(ds_reg + OFFSET_W'(stride_reg * STRIDE_W'(res_slot_reg))) : '0;

    // sequencer and page state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            full_reg      <= '0;
            row_valid_reg <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_W'(RST_CAP);
            stride_reg    <= STRIDE_W'(8);
            ds_reg        <= OFFSET_W'(RST_DS);
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_accept)
                    begin
                        stride_reg    <= stride_next;
                        count_reg     <= '0;
                        full_reg      <= '0;
                        row_valid_reg <= '0;
                        div_cnt_reg   <= DCNT_W'(NUM_W);
                        state_reg     <= S_DIV;
                    end
                    else if (in_accept)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    count_reg <= ex_count;
                    if (mem_we)
                    begin
                        full_reg[word_reg]      <= &mem_wdata;
                        row_valid_reg[word_reg] <= 1'b1;
                    end
                    state_reg <= S_OFFS;
                end
                S_OFFS:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                    if (div_cnt_reg == DCNT_W'(1))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    cap_reg   <= cap_next;
                    ds_reg    <= ds_next;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // request, result and divider payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg      <= req_t'(s_axis_tuser[REQ_W-1:0]);
            slot_reg     <= slot_in;
            word_reg     <= rd_addr;
            any_free_reg <= any_free;
            in_range_reg <= slot_in_range;
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
        if (state_reg == S_EXEC)
        begin
            res_status_reg <= ex_status;
            res_ok_reg     <= ex_ok;
            res_slot_reg   <= ex_slot;
            res_empty_reg  <= ex_empty;
        end
        if (cfg_accept)
        begin
            quo_reg <= NUM_W'(DIV_NUM);
            rem_reg <= '0;
        end
        else if (state_reg == S_DIV)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg[SLOT_OUT_W-1:0];
            out_offset_reg <= offset_next;
            out_count_reg  <= COUNT_W'(count_reg);
            out_empty_reg  <= res_empty_reg;
        end
    end

    // result word
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_count_reg, out_offset_reg, out_slot_reg};
    assign m_axis_tuser  = {out_empty_reg, out_status_reg};

endmodule

[rtl/rspm_checker.sv]
// port-level checks of the record slot page manager and their bind
module rspm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [rspm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [rspm_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import rspm_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

    // one request at a time: no request taken right after one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !cfg_ready)
    else $error("request taken while previous one in flight");

    // page is busy reformatting after a size write
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_axis_tready && !cfg_ready)
    else $error("request or size write taken during reformat");

    // page empty only with zero records
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |->
            m_axis_tdata[33:23] == '0 && m_axis_tuser[2:0] == ST_OK)
    else $error("page_empty with records left");

    // failed request carries no offset
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2:0] != ST_OK |-> m_axis_tdata[22:10] == '0)
    else $error("failed request with nonzero offset");

endmodule

bind record_slot_page_manager rspm_checker u_rspm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
